FILE: src/cigar_string_parser_unit_defines.svh
// assertion macros for the cigar string parser unit
`ifndef CIGAR_STRING_PARSER_UNIT_DEFINES_SVH
`define CIGAR_STRING_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication under clock and reset
`define CSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csp assertion failed");

// next-cycle implication under clock and reset
`define CSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csp assertion failed");

`else

`define CSP_ASSERT_IMP(lbl, ante, cons)
`define CSP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: src/csp_pkg.sv
// shared types and constants for the cigar string parser unit
package csp_pkg;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 4;
    localparam int DIGIT_W  = 4;
    localparam int OPLEN_W  = 32;
    localparam int STATUS_W = 3;

    // queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_N    = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
    localparam logic [CHAR_W-1:0] CH_H    = 8'h48;
    localparam logic [CHAR_W-1:0] CH_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

    // operation kind codes
    localparam logic [KIND_W-1:0] KIND_M  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_I  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_D  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_N  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_S  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_H  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_P  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_EQ = 4'd7;
    localparam logic [KIND_W-1:0] KIND_X  = 4'd8;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_BAD_OP   = 3'd3,
        ST_BAD_END  = 3'd4
    } status_t;

    // classified input item
    typedef struct packed {
        logic                is_digit;
        logic [DIGIT_W-1:0]  digit;
        logic                kind_ok;
        logic [KIND_W-1:0]   kind;
        logic                is_star;
        logic                no_char;
        logic                last;
    } item_t;

    // one result item
    typedef struct packed {
        logic                op_valid;
        logic [OPLEN_W-1:0]  op_length;
        logic [KIND_W-1:0]   op_kind;
        logic                end_of_string;
        status_t             status;
    } result_t;

endpackage

FILE: src/csp_front.sv
// front stage: accepts characters and classifies them into items
module csp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [csp_pkg::CHAR_W-1:0]    in_char,
    input  logic                          in_no_char,
    input  logic                          in_last,
    output logic                          push_valid,
    input  logic                          push_ready,
    output csp_pkg::item_t                push_item
);

    logic           valid_reg;
    logic           valid_next;
    csp_pkg::item_t item_reg;
    csp_pkg::item_t item_next;

    // classify the incoming character
    always_comb begin
        item_next          = '0;
        item_next.no_char  = in_no_char;
        item_next.last     = in_last;
        item_next.is_star  = (in_char == csp_pkg::CH_STAR);
        item_next.is_digit = (in_char inside {[csp_pkg::CH_0:csp_pkg::CH_9]});
        item_next.digit    = csp_pkg::DIGIT_W'(in_char - csp_pkg::CH_0);
        item_next.kind_ok  = 1'b1;
        case (in_char)
            csp_pkg::CH_M:  item_next.kind = csp_pkg::KIND_M;
            csp_pkg::CH_I:  item_next.kind = csp_pkg::KIND_I;
            csp_pkg::CH_D:  item_next.kind = csp_pkg::KIND_D;
            csp_pkg::CH_N:  item_next.kind = csp_pkg::KIND_N;
            csp_pkg::CH_S:  item_next.kind = csp_pkg::KIND_S;
            csp_pkg::CH_H:  item_next.kind = csp_pkg::KIND_H;
            csp_pkg::CH_P:  item_next.kind = csp_pkg::KIND_P;
            csp_pkg::CH_EQ: item_next.kind = csp_pkg::KIND_EQ;
            csp_pkg::CH_X:  item_next.kind = csp_pkg::KIND_X;
            default: begin
                item_next.kind    = csp_pkg::KIND_M;
                item_next.kind_ok = 1'b0;
            end
        endcase
    end

    // stage holds one item until the queue takes it
    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/csp_queue.sv
// short fifo of classified items between front and back
module csp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  csp_pkg::item_t  push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output csp_pkg::item_t  pop_item
);

    csp_pkg::item_t                entry_reg [csp_pkg::QUEUE_DEPTH];
    logic [csp_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [csp_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [csp_pkg::QPTR_W:0]      count_reg;
    logic [csp_pkg::QPTR_W:0]      count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != (csp_pkg::QPTR_W+1)'(csp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy update
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/csp_back.sv
// back stage: parser state, length accumulation and result register
module csp_back #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  csp_pkg::item_t    pop_item,
    output logic              res_valid,
    input  logic              res_ready,
    output csp_pkg::result_t  res_data
);

    localparam int EXT_W = LENGTH_WIDTH + 4;

    logic [LENGTH_WIDTH-1:0] acc_reg;
    logic [LENGTH_WIDTH-1:0] acc_next;
    logic                    digit_seen_reg;
    logic                    digit_seen_next;
    logic                    op_seen_reg;
    logic                    op_seen_next;
    logic                    error_hold_reg;
    logic                    error_hold_next;
    logic                    at_start_reg;
    logic                    at_start_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    csp_pkg::result_t        out_reg;
    csp_pkg::result_t        res_next;
    logic                    emit;
    logic                    do_pop;
    logic [EXT_W-1:0]        acc_ext;
    logic [EXT_W-1:0]        acc_mac;
    logic                    overflow;

    assign pop_ready = !out_valid_reg || res_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // acc * 10 + digit as shifts and adds, overflow when upper bits set
    assign acc_ext  = EXT_W'(acc_reg);
    assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(pop_item.digit);
    assign overflow = (acc_mac[EXT_W-1:LENGTH_WIDTH] != '0);

    // parser decisions for the item at the head of the queue
    always_comb begin
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        op_seen_next    = op_seen_reg;
        error_hold_next = error_hold_reg;
        at_start_next   = at_start_reg;
        emit            = 1'b0;
        res_next        = '0;
        res_next.end_of_string = 1'b1;
        res_next.status        = csp_pkg::ST_OK;

        if (error_hold_reg) begin
            // rest of a failed string is dropped
        end else if (pop_item.no_char) begin
            if (pop_item.last) begin
                emit = 1'b1;
                if (at_start_reg) begin
                    res_next.status = csp_pkg::ST_EMPTY;
                end else if (digit_seen_reg || !op_seen_reg) begin
                    res_next.status = csp_pkg::ST_BAD_END;
                end
            end
        end else if (pop_item.is_star && at_start_reg && pop_item.last) begin
            emit            = 1'b1;
            res_next.status = csp_pkg::ST_EMPTY;
        end else begin
            at_start_next = 1'b0;
            if (pop_item.is_digit) begin
                if (overflow) begin
                    emit            = 1'b1;
                    res_next.status = csp_pkg::ST_OVERFLOW;
                    error_hold_next = 1'b1;
                end else begin
                    acc_next        = acc_mac[LENGTH_WIDTH-1:0];
                    digit_seen_next = 1'b1;
                    if (pop_item.last) begin
                        emit            = 1'b1;
                        res_next.status = csp_pkg::ST_BAD_END;
                    end
                end
            end else if (!digit_seen_reg || (acc_reg == '0) || !pop_item.kind_ok) begin
                emit            = 1'b1;
                res_next.status = csp_pkg::ST_BAD_OP;
                error_hold_next = 1'b1;
            end else begin
                emit                   = 1'b1;
                res_next.op_valid      = 1'b1;
                res_next.op_length     = csp_pkg::OPLEN_W'(acc_reg);
                res_next.op_kind       = pop_item.kind;
                res_next.end_of_string = pop_item.last;
                op_seen_next           = 1'b1;
                acc_next               = '0;
                digit_seen_next        = 1'b0;
            end
        end

        // every last item returns the string state to its start
        if (pop_item.last) begin
            acc_next        = '0;
            digit_seen_next = 1'b0;
            op_seen_next    = 1'b0;
            error_hold_next = 1'b0;
            at_start_next   = 1'b1;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            op_seen_reg    <= 1'b0;
            error_hold_reg <= 1'b0;
            at_start_reg   <= 1'b1;
        end else if (do_pop) begin
            acc_reg        <= acc_next;
            digit_seen_reg <= digit_seen_next;
            op_seen_reg    <= op_seen_next;
            error_hold_reg <= error_hold_next;
            at_start_reg   <= at_start_next;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ready) begin
            out_valid_next = 1'b0;
        end
        if (do_pop && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop && emit) begin
            out_reg <= res_next;
        end
    end

endmodule

FILE: src/cigar_string_parser_unit.sv
// Top level of the cigar string parser: front classifier, item queue, back parser.
// A character is registered in the front stage, a queue entry and the output register
// before its result is valid. Throughput: one character per cycle unless the output
// stalls, set by the length multiply-add and state update in the back parser.
// Reset: synchronous active-low aresetn empties front stage, queue and output
// register and returns the parser to the start of a string.
`include "cigar_string_parser_unit_defines.svh"

module cigar_string_parser_unit #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic [0:0]  s_axis_tuser,   // [0] no_char
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] op_length, [35:32] op_kind, [39:36] zero
    output logic [3:0]  m_axis_tuser,   // [0] op_valid, [3:1] status
    output logic        m_axis_tlast    // end_of_string
);

    logic             push_valid;
    logic             push_ready;
    csp_pkg::item_t   push_item;
    logic             pop_valid;
    logic             pop_ready;
    csp_pkg::item_t   pop_item;
    csp_pkg::result_t res_data;

    csp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_no_char (s_axis_tuser[0]),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    csp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    csp_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res_data)
    );

    // pack the result item
    assign m_axis_tdata = {4'b0000, res_data.op_kind, res_data.op_length};
    assign m_axis_tuser = {res_data.status, res_data.op_valid};
    assign m_axis_tlast = res_data.end_of_string;

    // an emitted operation carries a nonzero length and ok status
    `CSP_ASSERT_IMP(a_op_len_nonzero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] != 32'd0)
    `CSP_ASSERT_IMP(a_op_status_ok, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[3:1] == csp_pkg::ST_OK)
    // any result without an operation closes the string
    `CSP_ASSERT_IMP(a_noop_closes, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
    // a full front stage that the queue refuses blocks new input next cycle unless the queue then has room
    `CSP_ASSERT_NXT(a_front_backpressure, push_valid && !push_ready && !s_axis_tready, !s_axis_tready || push_ready)

endmodule
